@@ rtl/core/salct_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// salct_pkg: shared types and constants for the LRU cache tag store
// Fixed field widths and the controller state encoding.
// ----------------------------------------------------------------------------
package salct_pkg;

  localparam int unsigned ADDR_W = 64;
  localparam int unsigned CNT_W  = 32;

  localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

  // controller state: clearing the tag rows after reset, then normal lookups
  typedef enum logic [1:0] {
    ST_CLEAR = 2'b01,
    ST_RUN   = 2'b10
  } state_e;

endpackage : salct_pkg
`default_nettype wire

@@ rtl/core/set_assoc_lru_cache_tags_top.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// set_assoc_lru_cache_tags_top: set-associative tag store with true LRU
// Looks up one byte address per transfer, reports hit/miss and running
// saturating hit and miss counts.
// ----------------------------------------------------------------------------
// One lookup is taken per clock while in_stall_o is low: the lookup first
// reads the set's row (valid, rank and tag of every way) from a row memory
// with one read and one write port into a read register, then compares the
// tags, picks the way, updates the LRU ranks and writes the row back while
// the result register is loaded. A lookup to the set last written takes the
// row from a write-forwarding register, so back-to-back hits on one set run
// at full rate. After reset the block clears the row memory, one set per
// cycle, and holds in_stall_o high meanwhile.
// LINE_BYTES and SETS must be powers of two; the set is taken from the
// address bits above the line offset and the tag from the bits above that.
module set_assoc_lru_cache_tags_top
  import salct_pkg::*;
#(
  parameter int unsigned WAYS       = 2,
  parameter int unsigned SETS       = 64,
  parameter int unsigned LINE_BYTES = 64
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,

  input  wire logic              in_valid_i,
  output logic                   in_stall_o,
  input  wire logic [ADDR_W-1:0] address_i,

  output logic                   out_valid_o,
  input  wire logic              out_stall_i,
  output logic                   hit_o,
  output logic [CNT_W-1:0]       hit_total_o,
  output logic [CNT_W-1:0]       miss_total_o
);

  localparam int unsigned OFF_W    = $clog2(LINE_BYTES);
  localparam int unsigned SET_BITS = $clog2(SETS);
  localparam int unsigned IDX_W    = (SETS > 1) ? SET_BITS : 1;
  localparam int unsigned TAG_W    = ADDR_W - OFF_W - SET_BITS;
  localparam int unsigned RANK_W   = (WAYS > 1) ? $clog2(WAYS) : 1;

  typedef struct packed {
    logic              vld;
    logic [RANK_W-1:0] rank;
    logic [TAG_W-1:0]  tag;
  } way_t;

  typedef way_t [WAYS-1:0] row_t;

  function automatic logic [WAYS-1:0] lowest_one(input logic [WAYS-1:0] vec);
    return vec & (~vec + WAYS'(1));
  endfunction

  // --------------------------------------------------------------------------
  // control state
  // --------------------------------------------------------------------------
  state_e           state_q, state_d;
  logic [IDX_W-1:0] clr_idx_q;

  logic             in_acc;
  logic             s1_adv;

  logic             s1_vld_q;
  logic [IDX_W-1:0] s1_idx_q;
  logic [TAG_W-1:0] s1_tag_q;
  row_t             rd_q;

  logic             lw_vld_q;
  logic [IDX_W-1:0] lw_idx_q;
  row_t             lw_row_q;

  logic [CNT_W-1:0] hit_cnt_q, hit_cnt_d;
  logic [CNT_W-1:0] miss_cnt_q, miss_cnt_d;

  logic             out_vld_q;
  logic             out_hit_q;
  logic [CNT_W-1:0] out_hit_tot_q;
  logic [CNT_W-1:0] out_miss_tot_q;

  logic [IDX_W-1:0] in_idx;
  logic             wr_en;
  logic [IDX_W-1:0] wr_idx;
  row_t             wr_row;

  row_t             row_cur;
  row_t             row_new;
  logic [WAYS-1:0]  hit_vec;
  logic [WAYS-1:0]  free_vec;
  logic [WAYS-1:0]  old_vec;
  logic [WAYS-1:0]  sel_vec;
  logic [WAYS-1:0]  mru_vec;
  logic             hit;
  logic             age_all;
  logic [RANK_W-1:0] old_rank;

  row_t mem [SETS];

  assign in_idx = (SETS > 1) ? address_i[OFF_W +: IDX_W] : '0;

  assign s1_adv     = s1_vld_q && (!out_vld_q || !out_stall_i);
  assign in_stall_o = (state_q != ST_RUN) || (s1_vld_q && !s1_adv);
  assign in_acc     = in_valid_i && !in_stall_o;

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_CLEAR: if (clr_idx_q == IDX_W'(SETS - 1)) state_d = ST_RUN;
      ST_RUN:   state_d = ST_RUN;
      default:  state_d = ST_CLEAR;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_CLEAR;
      clr_idx_q <= '0;
    end else begin
      state_q <= state_d;
      if (state_q == ST_CLEAR) clr_idx_q <= clr_idx_q + IDX_W'(1);
    end
  end

  // --------------------------------------------------------------------------
  // lookup stage: forward the last written row, compare, pick way, re-rank
  // --------------------------------------------------------------------------
  always_comb begin
    row_cur = (lw_vld_q && lw_idx_q == s1_idx_q) ? lw_row_q : rd_q;

    for (int w = 0; w < WAYS; w++) begin
      hit_vec[w]  = row_cur[w].vld && (row_cur[w].tag == s1_tag_q);
      free_vec[w] = !row_cur[w].vld;
      // full set holds ranks 0..WAYS-1, so the oldest has the top rank
      old_vec[w]  = row_cur[w].rank == RANK_W'(WAYS - 1);
    end

    hit     = |hit_vec;
    age_all = !hit && (|free_vec);
    if (hit)             sel_vec = lowest_one(hit_vec);
    else if (|free_vec)  sel_vec = lowest_one(free_vec);
    else                 sel_vec = lowest_one(old_vec);

    old_rank = '0;
    for (int w = 0; w < WAYS; w++) begin
      if (sel_vec[w]) old_rank = old_rank | row_cur[w].rank;
    end

    for (int w = 0; w < WAYS; w++) begin
      row_new[w] = row_cur[w];
      if (sel_vec[w]) begin
        row_new[w].vld  = 1'b1;
        row_new[w].rank = '0;
        row_new[w].tag  = s1_tag_q;
      end else if (row_cur[w].vld && (age_all || row_cur[w].rank < old_rank)) begin
        row_new[w].rank = row_cur[w].rank + RANK_W'(1);
      end
      mru_vec[w] = row_new[w].vld && (row_new[w].rank == '0);
    end
  end

  assign hit_cnt_d  = (hit && hit_cnt_q != CNT_MAX) ? hit_cnt_q + CNT_W'(1) : hit_cnt_q;
  assign miss_cnt_d = (!hit && miss_cnt_q != CNT_MAX) ? miss_cnt_q + CNT_W'(1)
                                                      : miss_cnt_q;

  // --------------------------------------------------------------------------
  // row memory: one write port (clear or update), one registered read port
  // --------------------------------------------------------------------------
  assign wr_en  = (state_q == ST_CLEAR) || s1_adv;
  assign wr_idx = (state_q == ST_CLEAR) ? clr_idx_q : s1_idx_q;
  assign wr_row = (state_q == ST_CLEAR) ? row_t'('0) : row_new;

  always_ff @(posedge clk_i) begin
    if (wr_en) mem[wr_idx] <= wr_row;
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) rd_q <= mem[in_idx];
  end

  // --------------------------------------------------------------------------
  // pipeline registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q   <= 1'b0;
      lw_vld_q   <= 1'b0;
      out_vld_q  <= 1'b0;
      hit_cnt_q  <= '0;
      miss_cnt_q <= '0;
    end else begin
      if (in_acc)      s1_vld_q <= 1'b1;
      else if (s1_adv) s1_vld_q <= 1'b0;
      if (wr_en)       lw_vld_q <= 1'b1;
      if (s1_adv)      out_vld_q <= 1'b1;
      else if (!out_stall_i) out_vld_q <= 1'b0;
      if (s1_adv) begin
        hit_cnt_q  <= hit_cnt_d;
        miss_cnt_q <= miss_cnt_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_idx_q <= in_idx;
      s1_tag_q <= address_i[ADDR_W-1 -: TAG_W];
    end
    if (wr_en) begin
      lw_idx_q <= wr_idx;
      lw_row_q <= wr_row;
    end
    if (s1_adv) begin
      out_hit_q      <= hit;
      out_hit_tot_q  <= hit_cnt_d;
      out_miss_tot_q <= miss_cnt_d;
    end
  end

  assign out_valid_o  = out_vld_q;
  assign hit_o        = out_hit_q;
  assign hit_total_o  = out_hit_tot_q;
  assign miss_total_o = out_miss_tot_q;

`ifndef SYNTHESIS
  // no lookup is taken while the row memory is being cleared
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_CLEAR) |-> in_stall_o)
    else $error("lookup accepted during clear");

  // an updated row has exactly one most recently used way
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_adv |-> ($countones(mru_vec) == 1))
    else $error("updated row has no unique MRU way");

  // a reported hit always carries a nonzero hit count
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && out_hit_q) |-> (out_hit_tot_q != '0))
    else $error("hit reported with zero hit count");

  // the counters only ever grow
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_adv |=> (hit_cnt_q >= $past(hit_cnt_q)) && (miss_cnt_q >= $past(miss_cnt_q)))
    else $error("counter decreased");

  // each lookup moves exactly one of the two counters unless it is saturated
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_adv && hit_cnt_q != CNT_MAX && miss_cnt_q != CNT_MAX)
      |=> ((hit_cnt_q != $past(hit_cnt_q)) != (miss_cnt_q != $past(miss_cnt_q))))
    else $error("counter update mismatch");
`endif

endmodule : set_assoc_lru_cache_tags_top
`default_nettype wire

@@ tb/set_assoc_lru_cache_tags_top_tb.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// set_assoc_lru_cache_tags_top_tb: self-checking bench for the LRU tag store
// Sends byte addresses through the lookup port and tracks its own copy of
// the tags, valid bits, LRU ranks and hit/miss counts. Each result is
// checked against the oldest open lookup. The stimulus starts with a
// directed sequence of fills, hits and evictions. A random mix follows:
// hot sets and tags, repeated lines and full-width addresses, with random
// gaps on both sides of the block.
// ----------------------------------------------------------------------------
module set_assoc_lru_cache_tags_top_tb;
  import salct_pkg::*;

  localparam int unsigned WAYS        = 2;
  localparam int unsigned SETS        = 64;
  localparam int unsigned LINE_BYTES  = 64;
  localparam int unsigned OFFSET_W    = $clog2(LINE_BYTES);
  localparam int unsigned SET_W       = $clog2(SETS);
  localparam int unsigned TAG_W       = ADDR_W - SET_W - OFFSET_W;
  localparam int unsigned RAND_ITEMS  = 1800;
  localparam int unsigned CYCLE_LIMIT = 1_000_000;

  typedef struct packed {
    logic             hit;
    logic [CNT_W-1:0] hits;
    logic [CNT_W-1:0] misses;
  } outcome_t;

  // Tracks the tag store contents and holds the outcomes still owed by the block.
  class lru_lookup_tracker;
    logic [TAG_W-1:0] tag_mem   [SETS][WAYS];
    bit               way_valid [SETS][WAYS];
    int unsigned      way_rank  [SETS][WAYS];
    logic [CNT_W-1:0] hit_cnt;
    logic [CNT_W-1:0] miss_cnt;
    outcome_t         pending_outcomes[$];
    int unsigned      mismatches;

    function new();
      for (int s = 0; s < SETS; s++) begin
        for (int w = 0; w < WAYS; w++) begin
          way_valid[s][w] = 1'b0;
          way_rank[s][w]  = 0;
        end
      end
      hit_cnt    = '0;
      miss_cnt   = '0;
      mismatches = 0;
    endfunction

    // Valid ways ranked more recent than old_rank age by one; way w becomes MRU.
    function void make_mru(int unsigned s, int unsigned w, int unsigned old_rank);
      for (int k = 0; k < WAYS; k++) begin
        if (k != w && way_valid[s][k] && way_rank[s][k] < old_rank) way_rank[s][k]++;
      end
      way_rank[s][w] = 0;
    endfunction

    function void note_lookup(logic [ADDR_W-1:0] addr);
      int unsigned      set_idx;
      int unsigned      hit_way;
      int unsigned      free_way;
      int unsigned      victim;
      int unsigned      old_rank;
      logic [TAG_W-1:0] line_tag;
      outcome_t         outcome;
      set_idx  = 32'(addr[OFFSET_W +: SET_W]);
      line_tag = addr[ADDR_W-1 -: TAG_W];
      hit_way  = WAYS;
      free_way = WAYS;
      for (int w = 0; w < WAYS; w++) begin
        if (way_valid[set_idx][w]) begin
          if (hit_way == WAYS && tag_mem[set_idx][w] == line_tag) hit_way = w;
        end else if (free_way == WAYS) begin
          free_way = w;
        end
      end
      if (hit_way < WAYS) begin
        if (hit_cnt != CNT_MAX) hit_cnt++;
        make_mru(set_idx, hit_way, way_rank[set_idx][hit_way]);
        outcome.hit = 1'b1;
      end else begin
        if (miss_cnt != CNT_MAX) miss_cnt++;
        if (free_way < WAYS) begin
          victim   = free_way;
          old_rank = 32'hFFFF_FFFF;
        end else begin
          // oldest way goes; lowest way on a tie
          victim = 0;
          for (int w = 1; w < WAYS; w++) begin
            if (way_rank[set_idx][w] > way_rank[set_idx][victim]) victim = w;
          end
          old_rank = way_rank[set_idx][victim];
        end
        tag_mem[set_idx][victim]   = line_tag;
        way_valid[set_idx][victim] = 1'b1;
        make_mru(set_idx, victim, old_rank);
        outcome.hit = 1'b0;
      end
      outcome.hits   = hit_cnt;
      outcome.misses = miss_cnt;
      pending_outcomes.insert(pending_outcomes.size(), outcome);
    endfunction

    function void check_outcome(logic hit, logic [CNT_W-1:0] hits, logic [CNT_W-1:0] misses);
      outcome_t want;
      if (pending_outcomes.size() == 0) begin
        $error("result transfer with no lookup outstanding");
        mismatches++;
        return;
      end
      want = pending_outcomes.pop_front();
      if (hit !== want.hit) begin
        $error("hit: expected %0d, got %0d", want.hit, hit);
        mismatches++;
      end
      if (hits !== want.hits) begin
        $error("hit_total: expected %0d, got %0d", want.hits, hits);
        mismatches++;
      end
      if (misses !== want.misses) begin
        $error("miss_total: expected %0d, got %0d", want.misses, misses);
        mismatches++;
      end
    endfunction
  endclass

  logic              clk_i       = 1'b0;
  logic              rst_ni      = 1'b0;
  logic              in_valid_i  = 1'b0;
  logic              in_stall_o;
  logic [ADDR_W-1:0] address_i   = '0;
  logic              out_valid_o;
  logic              out_stall_i = 1'b0;
  logic              hit_o;
  logic [CNT_W-1:0]  hit_total_o;
  logic [CNT_W-1:0]  miss_total_o;

  lru_lookup_tracker tracker;
  bit                calm = 1'b1;
  int unsigned       cycle_count = 0;
  int unsigned       hot_sets[4];
  logic [TAG_W-1:0]  hot_tags[3];
  logic [ADDR_W-1:0] last_addr = '0;

  set_assoc_lru_cache_tags_top #(
    .WAYS       (WAYS),
    .SETS       (SETS),
    .LINE_BYTES (LINE_BYTES)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .address_i    (address_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .hit_o        (hit_o),
    .hit_total_o  (hit_total_o),
    .miss_total_o (miss_total_o)
  );

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  initial begin
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  // mostly short gaps, now and then a long one
  function automatic int unsigned idle_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [ADDR_W-1:0] make_addr(logic [TAG_W-1:0] tag,
                                                  int unsigned set_idx,
                                                  int unsigned offset);
    logic [SET_W-1:0]    set_bits;
    logic [OFFSET_W-1:0] offset_bits;
    set_bits    = SET_W'(set_idx);
    offset_bits = OFFSET_W'(offset);
    return {tag, set_bits, offset_bits};
  endfunction

  function automatic logic [ADDR_W-1:0] random_addr();
    int unsigned       r;
    logic [ADDR_W-1:0] raw;
    r   = $urandom_range(0, 99);
    raw = {$urandom, $urandom};
    if (r < 15) return raw;
    if (r < 30) return {last_addr[ADDR_W-1:OFFSET_W], raw[OFFSET_W-1:0]};
    return make_addr(hot_tags[$urandom_range(0, 2)], hot_sets[$urandom_range(0, 3)],
                     32'(raw[OFFSET_W-1:0]));
  endfunction

  // three tags over a few sets keep both ways busy and force evictions
  task automatic refresh_hot_lines();
    logic [ADDR_W-1:0] raw;
    foreach (hot_sets[i]) hot_sets[i] = $urandom_range(0, SETS - 1);
    foreach (hot_tags[i]) begin
      raw = {$urandom, $urandom};
      hot_tags[i] = raw[TAG_W-1:0];
    end
  endtask

  task automatic issue_lookup(input logic [ADDR_W-1:0] addr);
    int unsigned gap;
    gap = calm ? 0 : idle_len();
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    address_i  <= addr;
    do @(posedge clk_i); while (in_stall_o);
    tracker.note_lookup(addr);
    last_addr = addr;
  endtask

  task automatic drain_results();
    in_valid_i <= 1'b0;
    while (tracker.pending_outcomes.size() != 0) @(posedge clk_i);
  endtask

  initial begin
    int unsigned hold;
    hold = 0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold != 0) begin
        out_stall_i <= 1'b1;
        hold--;
      end else begin
        out_stall_i <= 1'b0;
        if (!calm) hold = idle_len();
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      tracker.check_outcome(hit_o, hit_total_o, miss_total_o);
    end
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("RESULT: ERROR");
    $finish;
  end

  initial begin
    logic [ADDR_W-1:0] directed_addrs[$];
    tracker = new();
    // fills, MRU promotion and LRU eviction in set 0 and set 63, fills in sets 21 and 42, extreme tags
    directed_addrs = '{
      64'h0, 64'h3F, '1, make_addr('1, 63, 0),
      make_addr(TAG_W'(1), 0, 0), make_addr('0, 0, 5), make_addr(TAG_W'(2), 0, 9),
      make_addr(TAG_W'(1), 0, 63), make_addr(TAG_W'(2), 0, 0), make_addr('1, 0, 0),
      64'h8000_0000_0000_0000, make_addr('1, 0, 32),
      make_addr('0, 63, 0), '1,
      make_addr(52'h5555555555555, 42, 21), make_addr(52'hAAAAAAAAAAAAA, 21, 42),
      make_addr(52'h5555555555555, 42, 0), make_addr(52'hAAAAAAAAAAAAA, 21, 63),
      make_addr('0, 63, 7), make_addr(TAG_W'(5), 63, 0), '1
    };
    @(posedge rst_ni);
    @(posedge clk_i);
    calm = 1'b1;
    foreach (directed_addrs[i]) issue_lookup(directed_addrs[i]);
    drain_results();

    refresh_hot_lines();
    calm = 1'b0;
    for (int n = 0; n < RAND_ITEMS; n++) begin
      if (n % 200 == 199) refresh_hot_lines();
      if (n % 150 == 0) calm = ($urandom_range(0, 3) == 0);
      if (n == RAND_ITEMS / 2) drain_results();
      issue_lookup(random_addr());
    end

    drain_results();
    repeat (8) @(posedge clk_i);
    if (tracker.pending_outcomes.size() != 0) begin
      $error("%0d lookups left without a result", tracker.pending_outcomes.size());
    end
    if (tracker.mismatches == 0 && tracker.pending_outcomes.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule : set_assoc_lru_cache_tags_top_tb
`default_nettype wire
